// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module of the frame rate meter.
// Each macro wraps one concurrent assertion clocked on a rising edge with a reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define FRM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next clock cycle.
`define FRM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/frm_pkg.sv =====
// Shared constants, types and state encoding for the frame rate meter.
// Used by every module of the block; depends on nothing else.
package frm_pkg;

   localparam int RING_DEPTH  = 10;
   localparam int RING_SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int RATE_W      = 24;
   localparam int RING_SUM_W  = RATE_W + RING_SLOT_W;
   localparam int FRAC_W      = 8;

   localparam int STAMP_W = 64;
   localparam int SUM_W   = STAMP_W + 1;
   localparam int DELTA_W = 32;
   localparam int TOTAL_W = 48;
   localparam int HALF_W  = 33;
   localparam int COUNT_W = 32;
   localparam int SHOWN_W = 16;
   localparam int TICK_W  = 32;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 200;
   localparam int RSP_USER_W = 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DIV_Q_W   = RATE_W;
   localparam int DIV_R_W   = TOTAL_W;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

   localparam int MUL_W     = 32;
   localparam int MUL_CNT_W = $clog2(MUL_W + 1);

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [HALF_W-1:0]  HALF_MAX  = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [DIV_R_W-1:0] SHOWN_DIVISOR = DIV_R_W'(RING_DEPTH * (1 << FRAC_W));
   localparam logic [TICK_W-1:0]  TICK_RATE_RESET = TICK_W'(10000000);
   localparam logic               PAUSED_RESET    = 1'b1;

   typedef enum logic [0:0] {
      REG_TICK_RATE = 1'b0,
      REG_PAUSED    = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELTA,
      ST_RATE_GO,
      ST_RATE_WAIT,
      ST_RING,
      ST_HALF,
      ST_SHOWN_WAIT,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_OVR_GO,
      ST_OVR_WAIT,
      ST_DONE
   } fsm_state_type;

   typedef struct packed {
      logic               start;
      logic [DIV_R_W-1:0] num_hi;
      logic [DIV_Q_W-1:0] num_lo;
      logic [DIV_R_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic [2*MUL_W-1:0] prod;
   } mul_rsp_type;

endpackage

// ===== rtl/core/frm_div.sv =====
// Bit-serial restoring divider with a saturating 24-bit quotient.
// Depends on frm_pkg for widths and the request and response structs.
module frm_div import frm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_R_W-1:0]   rem_ff, rem_in;
   logic [DIV_R_W-1:0]   den_ff, den_in;
   logic [DIV_Q_W-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_R_W:0]     trial;
   logic [DIV_R_W:0]     diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_Q_W-1]};
      diff    = trial - {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         den_in = div_req.den;
         cnt_in = DIV_CNT_W'(DIV_Q_W);
         // A quotient that would not fit, division by zero included, saturates.
         if (div_req.num_hi >= div_req.den) begin
            rem_in  = '0;
            quo_in  = '1;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in  = div_req.num_hi;
            quo_in  = div_req.num_lo;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!diff[DIV_R_W]) begin
            rem_in = diff[DIV_R_W-1:0];
            quo_in = {quo_ff[DIV_Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_R_W-1:0];
            quo_in = {quo_ff[DIV_Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

// ===== rtl/core/frm_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on frm_pkg for widths and the request and response structs.
module frm_mul import frm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic [2*MUL_W-1:0] prod_ff, prod_in;
   logic [MUL_W-1:0]   mcand_ff, mcand_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [MUL_W:0]     sum;

   always_comb begin
      sum      = {1'b0, prod_ff[2*MUL_W-1:MUL_W]}
               + (prod_ff[0] ? {1'b0, mcand_ff} : {(MUL_W+1){1'b0}});
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (mul_req.start) begin
         prod_in  = {{MUL_W{1'b0}}, mul_req.b};
         mcand_in = mul_req.a;
         cnt_in   = MUL_CNT_W'(MUL_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // The upper half accumulates while the multiplier bits shift out below.
         prod_in = {sum, prod_ff[MUL_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.prod = prod_ff;

endmodule

// ===== rtl/core/frame_rate_meter.sv =====
// Frame rate meter: each input beat is a frame tick carrying a 64-bit counter timestamp, and
// each one yields one result beat with frame delta, totals, the shown rate averaged over the
// last ten frames and refreshed every half second, and the overall rate in 16.8 fixed point.
// The block works on one beat at a time: the next beat is taken only after the result of the
// last one has gone to the output register. The time that a beat takes is set by the
// bit-serial divider and the bit-serial multiplier. The divider runs up to three times per
// beat and skips its quotient steps when the quotient saturates. The first beat after reset
// only records its timestamp. A finished result waits in an output register while the next
// beat is taken, and the input stalls only when that next beat is finished before the waiting
// result has left.
// Depends on frm_pkg, frm_div and frm_mul.
module frame_rate_meter import frm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [63:0] timestamp
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] engine_delta_ticks, [79:32] engine_time_ticks, [111:80] game_delta_ticks,
   // [159:112] game_time_ticks, [175:160] shown_rate, [199:176] overall_rate
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [0] rate_updated
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   fsm_state_type state_ff, state_in;

   logic [TICK_W-1:0]     tick_rate_ff, tick_rate_in;
   logic                  paused_ff, paused_in;
   logic [STAMP_W-1:0]    stamp_ff, stamp_in;
   logic [STAMP_W-1:0]    last_stamp_ff, last_stamp_in;
   logic                  seen_ff, seen_in;
   logic [RATE_W-1:0]     ring_ff [RING_DEPTH];
   logic [RING_SLOT_W-1:0] slot_ff, slot_in;
   logic [RING_SUM_W-1:0] ring_sum_ff, ring_sum_in;
   logic [HALF_W-1:0]     half_ff, half_in;
   logic [TOTAL_W-1:0]    engine_ff, engine_in;
   logic [TOTAL_W-1:0]    game_ff, game_in;
   logic [COUNT_W-1:0]    frames_ff, frames_in;
   logic [SHOWN_W-1:0]    latched_ff, latched_in;
   logic [DELTA_W-1:0]    delta_ff, delta_in;
   logic [DELTA_W-1:0]    gdelta_ff, gdelta_in;
   logic [RATE_W-1:0]     rate_ff, rate_in;
   logic [RATE_W-1:0]     overall_ff, overall_in;
   logic                  updated_ff, updated_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                  csr_wr;
   csr_index_type         csr_index;
   logic                  half_due;
   logic                  rsp_load;
   logic                  ring_wr;
   logic [STAMP_W-1:0]    full;
   logic [DELTA_W-1:0]    delta_sat;
   logic [SUM_W-1:0]      eng_sum;
   logic [SUM_W-1:0]      game_sum;
   logic [SUM_W-1:0]      half_sum;
   logic [RATE_W-1:0]     old_rate;

   div_req_type div_req;
   div_rsp_type div_rsp;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   frm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   frm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_index)
         REG_TICK_RATE: csr_prdata = tick_rate_ff;
         REG_PAUSED:    csr_prdata = {{(CSR_DATA_W-1){1'b0}}, paused_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign half_due = {half_ff, 1'b0} >= (HALF_W+1)'(tick_rate_ff);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_tvalid) state_in = ST_DELTA;
         ST_DELTA:      state_in = seen_ff ? ST_RATE_GO : ST_MUL_GO;
         ST_RATE_GO:    state_in = ST_RATE_WAIT;
         ST_RATE_WAIT:  if (div_rsp.done) state_in = ST_RING;
         ST_RING:       state_in = ST_HALF;
         ST_HALF:       state_in = half_due ? ST_SHOWN_WAIT : ST_MUL_GO;
         ST_SHOWN_WAIT: if (div_rsp.done) state_in = ST_MUL_GO;
         ST_MUL_GO:     state_in = (frames_ff == '0) ? ST_DONE : ST_MUL_WAIT;
         ST_MUL_WAIT:   if (mul_rsp.done) state_in = ST_OVR_GO;
         ST_OVR_GO:     state_in = ST_OVR_WAIT;
         ST_OVR_WAIT:   if (div_rsp.done) state_in = ST_DONE;
         ST_DONE:       if (rsp_load) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Control outputs and operand selection for the divider and the multiplier.
   always_comb begin
      req_tready     = 1'b0;
      ring_wr        = 1'b0;
      div_req        = '0;
      mul_req        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_RATE_GO: begin
            div_req.start  = 1'b1;
            div_req.num_hi = DIV_R_W'(tick_rate_ff[TICK_W-1:DIV_Q_W-FRAC_W]);
            div_req.num_lo = {tick_rate_ff[DIV_Q_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            div_req.den    = DIV_R_W'(delta_ff);
         end
         ST_RING: begin
            ring_wr = 1'b1;
         end
         ST_HALF: begin
            if (half_due) begin
               div_req.start  = 1'b1;
               div_req.num_hi = DIV_R_W'(ring_sum_ff >> DIV_Q_W);
               div_req.num_lo = ring_sum_ff[DIV_Q_W-1:0];
               div_req.den    = SHOWN_DIVISOR;
            end
         end
         ST_MUL_GO: begin
            mul_req.start = (frames_ff != '0);
            mul_req.a     = frames_ff;
            mul_req.b     = tick_rate_ff;
         end
         ST_OVR_GO: begin
            div_req.start  = 1'b1;
            div_req.num_hi = mul_rsp.prod[2*MUL_W-1:DIV_Q_W-FRAC_W];
            div_req.num_lo = {mul_rsp.prod[DIV_Q_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
            div_req.den    = engine_ff;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      full      = stamp_ff - last_stamp_ff;
      delta_sat = (|full[STAMP_W-1:DELTA_W]) ? '1 : full[DELTA_W-1:0];
      eng_sum   = {1'b0, full} + SUM_W'(engine_ff);
      game_sum  = {1'b0, full} + SUM_W'(game_ff);
      half_sum  = {1'b0, full} + SUM_W'(half_ff);
      old_rate  = ring_ff[slot_ff];

      tick_rate_in  = tick_rate_ff;
      paused_in     = paused_ff;
      stamp_in      = stamp_ff;
      last_stamp_in = last_stamp_ff;
      seen_in       = seen_ff;
      slot_in       = slot_ff;
      ring_sum_in   = ring_sum_ff;
      half_in       = half_ff;
      engine_in     = engine_ff;
      game_in       = game_ff;
      frames_in     = frames_ff;
      latched_in    = latched_ff;
      delta_in      = delta_ff;
      gdelta_in     = gdelta_ff;
      rate_in       = rate_ff;
      overall_in    = overall_ff;
      updated_in    = updated_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      if (csr_wr) begin
         unique case (csr_index)
            REG_TICK_RATE: tick_rate_in = csr_pwdata[TICK_W-1:0];
            REG_PAUSED:    paused_in    = csr_pwdata[0];
            default:       paused_in    = paused_ff;
         endcase
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               stamp_in = req_tdata;
            end
         end
         ST_DELTA: begin
            updated_in    = 1'b0;
            last_stamp_in = stamp_ff;
            seen_in       = 1'b1;
            if (!seen_ff) begin
               delta_in  = '0;
               gdelta_in = '0;
            end else begin
               delta_in  = delta_sat;
               engine_in = (eng_sum >= SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                          : eng_sum[TOTAL_W-1:0];
               half_in   = (half_sum >= SUM_W'(HALF_MAX)) ? HALF_MAX
                                                          : half_sum[HALF_W-1:0];
               frames_in = (frames_ff == COUNT_MAX) ? COUNT_MAX : frames_ff + 1'b1;
               if (paused_ff) begin
                  gdelta_in = '0;
               end else begin
                  gdelta_in = delta_sat;
                  game_in   = (game_sum >= SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                              : game_sum[TOTAL_W-1:0];
               end
            end
         end
         ST_RATE_WAIT: begin
            if (div_rsp.done) begin
               rate_in = div_rsp.quot;
            end
         end
         ST_RING: begin
            ring_sum_in = ring_sum_ff - RING_SUM_W'(old_rate) + RING_SUM_W'(rate_ff);
            slot_in     = (slot_ff == RING_SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
         end
         ST_HALF: begin
            if (half_due) begin
               half_in    = '0;
               updated_in = 1'b1;
            end
         end
         ST_SHOWN_WAIT: begin
            if (div_rsp.done) begin
               latched_in = div_rsp.quot[SHOWN_W-1:0];
            end
         end
         ST_MUL_GO: begin
            if (frames_ff == '0) begin
               overall_in = '0;
            end
         end
         ST_OVR_WAIT: begin
            if (div_rsp.done) begin
               overall_in = div_rsp.quot;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {overall_ff, latched_ff, game_ff, gdelta_ff, engine_ff, delta_ff};
               rsp_user_in  = updated_ff;
            end
         end
         default: begin
            seen_in = seen_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_rate_ff  <= TICK_RATE_RESET;
         paused_ff     <= PAUSED_RESET;
         last_stamp_ff <= '0;
         seen_ff       <= 1'b0;
         slot_ff       <= '0;
         ring_sum_ff   <= '0;
         half_ff       <= '0;
         engine_ff     <= '0;
         game_ff       <= '0;
         frames_ff     <= '0;
         latched_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_rate_ff  <= tick_rate_in;
         paused_ff     <= paused_in;
         last_stamp_ff <= last_stamp_in;
         seen_ff       <= seen_in;
         slot_ff       <= slot_in;
         ring_sum_ff   <= ring_sum_in;
         half_ff       <= half_in;
         engine_ff     <= engine_in;
         game_ff       <= game_in;
         frames_ff     <= frames_in;
         latched_ff    <= latched_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (ring_wr) begin
         ring_ff[slot_ff] <= rate_ff;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff    <= stamp_in;
      delta_ff    <= delta_in;
      gdelta_ff   <= gdelta_in;
      rate_ff     <= rate_in;
      overall_ff  <= overall_in;
      updated_ff  <= updated_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/core/frm_checker.sv =====
// Port-level checker for the frame rate meter, bound to the top level below.
// Depends on frm_pkg and on the assertion macros in assert_macros.svh.
`include "assert_macros.svh"

module frm_checker import frm_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   `FRM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result beat changed")
   `FRM_ASSERT_NEXT(a_one_beat, clock, reset, req_tvalid && req_tready, !req_tready, "input taken while a beat is in work")
   `FRM_ASSERT(a_game_delta, clock, reset, rsp_tvalid |-> (rsp_tdata[111:80] == 32'd0 || rsp_tdata[111:80] == rsp_tdata[31:0]), "game delta is neither zero nor the engine delta")
   `FRM_ASSERT(a_game_time, clock, reset, rsp_tvalid |-> (rsp_tdata[159:112] <= rsp_tdata[79:32]), "game time ran ahead of engine time")

endmodule

bind frame_rate_meter frm_checker u_frm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
